// File: rtl/tcw_pkg.sv
// Shared types, constants and helpers of the text console character writer.
package tcw_pkg;

  // Screen geometry limits
  localparam int MAX_COLS   = 80;
  localparam int MAX_ROWS   = 25;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

  // Field and storage widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int TOT_W  = $clog2(CELL_COUNT + 1);
  localparam int PROD_W = COL_W + ROW_W;

  // Front-to-back queue sizing
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Cell and character codes
  localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0700;
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_ATTR    = 2'd2;

  localparam logic [COL_W-1:0]  COLS_RST = 7'd80;
  localparam logic [ROW_W-1:0]  ROWS_RST = 5'd25;
  localparam logic [CHAR_W-1:0] ATTR_RST = 8'h07;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;
    logic [IDX_W-1:0]  cell_index;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [IDX_W-1:0]  hardware_cursor;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_attr;
    logic              scrolled;
  } out_t;

  typedef struct packed {
    logic [COL_W-1:0]  columns;
    logic [ROW_W-1:0]  rows;
    logic [CHAR_W-1:0] text_attribute;
  } cfg_t;

  // Item class decided by the front end
  typedef enum logic [2:0] {
    K_READ,
    K_NUL,
    K_TAB,
    K_NL,
    K_CR,
    K_PRINT
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;
    logic [IDX_W-1:0]  cell_index;
  } q_entry_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_out_t;

  // Clamp the column register into 1..MAX_COLS
  function automatic logic [COL_W-1:0] eff_cols(input logic [COL_W-1:0] c);
    logic [COL_W-1:0] r;
    if (c == '0) begin
      r = COL_W'(1);
    end else if (c > COL_W'(MAX_COLS)) begin
      r = COL_W'(MAX_COLS);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Clamp the row register into 1..MAX_ROWS
  function automatic logic [ROW_W-1:0] eff_rows(input logic [ROW_W-1:0] c);
    logic [ROW_W-1:0] r;
    if (c == '0) begin
      r = ROW_W'(1);
    end else if (c > ROW_W'(MAX_ROWS)) begin
      r = ROW_W'(MAX_ROWS);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

// File: rtl/text_console_character_writer.sv
// Top level of the text console character writer: register port, front end and back end.
//
//   channel  | handshake              | beat payload
//   ---------+------------------------+--------------------------------------
//   input    | in_valid / in_ready    | in_data (operation, char, eos, index)
//   result   | out_valid / out_ready  | out_data (cursor, hw cursor, cell)
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready high)
//
// A put or read passes through the back-end sequencer states take, execute,
// latch or read wait, and result. A scroll adds a copy pass (one cell copy a
// cycle, then a drain write and the bottom row fill); a clear on a screen of
// two or fewer rows adds a pass that writes all columns*rows cells.
// After reset a clearing pass writes all 2000 cells, one a cycle; in_ready
// stays low until that pass ends. A two-entry queue keeps accepting beats
// while the back end works or the result register waits on out_ready.
module text_console_character_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcw_pkg::out_t       out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  tcw_pkg::cfg_t   cfg_r, cfg_nxt;
  tcw_pkg::q_out_t q_bus;
  logic            q_pop;
  logic            init_done;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        tcw_pkg::REG_COLUMNS: cfg_nxt.columns        = pwdata[tcw_pkg::COL_W-1:0];
        tcw_pkg::REG_ROWS:    cfg_nxt.rows           = pwdata[tcw_pkg::ROW_W-1:0];
        tcw_pkg::REG_ATTR:    cfg_nxt.text_attribute = pwdata[tcw_pkg::CHAR_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns        <= tcw_pkg::COLS_RST;
      cfg_r.rows           <= tcw_pkg::ROWS_RST;
      cfg_r.text_attribute <= tcw_pkg::ATTR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      tcw_pkg::REG_COLUMNS: prdata = 32'(cfg_r.columns);
      tcw_pkg::REG_ROWS:    prdata = 32'(cfg_r.rows);
      tcw_pkg::REG_ATTR:    prdata = 32'(cfg_r.text_attribute);
      default:              prdata = '0;
    endcase
  end

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_out     (q_bus),
    .q_pop     (q_pop)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_in      (q_bus),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcw_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module tcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             init_done,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcw_pkg::in_t     in_data,
  output tcw_pkg::q_out_t  q_out,
  input  logic             q_pop
);

  tcw_pkg::q_entry_t            entry_r [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::Q_CNT_W-1:0]  count_r, count_nxt;
  tcw_pkg::q_entry_t            cls;
  logic                         push;
  logic                         pop;

  // Classify the incoming beat
  always_comb begin
    cls.char_code     = in_data.char_code;
    cls.end_of_string = in_data.end_of_string;
    cls.cell_index    = in_data.cell_index;
    if (in_data.operation) begin
      cls.kind = tcw_pkg::K_READ;
    end else begin
      case (in_data.char_code)
        tcw_pkg::CH_NUL: cls.kind = tcw_pkg::K_NUL;
        tcw_pkg::CH_TAB: cls.kind = tcw_pkg::K_TAB;
        tcw_pkg::CH_NL:  cls.kind = tcw_pkg::K_NL;
        tcw_pkg::CH_CR:  cls.kind = tcw_pkg::K_CR;
        default:         cls.kind = tcw_pkg::K_PRINT;
      endcase
    end
  end

  assign in_ready    = init_done && (count_r != tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH));
  assign push        = in_valid && in_ready;
  assign pop         = q_pop && (count_r != '0);
  assign q_out.valid = (count_r != '0);
  assign q_out.entry = entry_r[rd_ptr_r];

  // Queue pointers, wrapping at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ? '0
                 : wr_ptr_r + tcw_pkg::Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ? '0
                 : rd_ptr_r + tcw_pkg::Q_PTR_W'(1);
    end
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + tcw_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - tcw_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/tcw_back.sv
// Back end: cursor, screen store sequencing (put, read, scroll, clear) and result register.
module tcw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tcw_pkg::cfg_t    cfg,
  input  tcw_pkg::q_out_t  q_in,
  output logic             q_pop,
  output logic             init_done,
  output logic             out_valid,
  input  logic             out_ready,
  output tcw_pkg::out_t    out_data
);

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_CALC   = 10'b0000000100,
    S_RDWAIT = 10'b0000001000,
    S_LATCH  = 10'b0000010000,
    S_CLR    = 10'b0000100000,
    S_COPY   = 10'b0001000000,
    S_DRAIN  = 10'b0010000000,
    S_FILL   = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_t;

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              cnt_r, cnt_nxt;
  logic [AW-1:0]              last_r, last_nxt;
  tcw_pkg::q_entry_t          item_r, item_nxt;
  logic [CW-1:0]              col_r, col_nxt;
  logic [RW-1:0]              row_r, row_nxt;
  logic [tcw_pkg::IDX_W-1:0]  latch_r, latch_nxt;
  logic                       scr_r, scr_nxt;
  logic                       rd_ok_r, rd_ok_nxt;
  logic [tcw_pkg::CHAR_W-1:0] rc_r, rc_nxt;
  logic [tcw_pkg::CHAR_W-1:0] ra_r, ra_nxt;
  logic                       pend_r, pend_nxt;
  logic [AW-1:0]              pend_addr_r, pend_addr_nxt;
  logic [tcw_pkg::TOT_W-1:0]  total_r, total_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tcw_pkg::out_t              out_r, out_nxt;

  logic [CW-1:0]               cols_e;
  logic [RW-1:0]               rows_e;
  logic [tcw_pkg::PROD_W-1:0]  lin_prod;
  logic [tcw_pkg::PROD_W-1:0]  geo_prod;
  logic [CW-1:0]               nc;
  logic [RW-1:0]               nr;
  logic [CW-1:0]               nc_w;
  logic [RW-1:0]               nr_w;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  assign cols_e = tcw_pkg::eff_cols(cfg.columns);
  assign rows_e = tcw_pkg::eff_rows(cfg.rows);

  // Linear cursor position and screen size
  assign lin_prod = tcw_pkg::PROD_W'(row_r) * tcw_pkg::PROD_W'(cols_e)
                  + tcw_pkg::PROD_W'(col_r);
  assign geo_prod = tcw_pkg::PROD_W'(rows_e) * tcw_pkg::PROD_W'(cols_e);

  // Cursor move for the queued character
  always_comb begin
    nc = col_r;
    nr = row_r;
    case (item_r.kind)
      tcw_pkg::K_TAB: begin
        nc = {col_r[CW-1:2], 2'b11} + CW'(1);
      end
      tcw_pkg::K_NL: begin
        nc = '0;
        nr = row_r + RW'(1);
      end
      tcw_pkg::K_CR: begin
        nc = '0;
      end
      tcw_pkg::K_PRINT: begin
        nc = col_r + CW'(1);
      end
      default: begin
        nc = col_r;
      end
    endcase
    // wrap past the last column
    if (nc >= cols_e) begin
      nc_w = '0;
      nr_w = nr + RW'(1);
    end else begin
      nc_w = nc;
      nr_w = nr;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    item_nxt      = item_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    latch_nxt     = latch_r;
    scr_nxt       = scr_r;
    rd_ok_nxt     = rd_ok_r;
    rc_nxt        = rc_r;
    ra_nxt        = ra_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    total_nxt     = total_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    ram_raddr     = cnt_r;

    case (state_r)
      // clear the whole store after reset
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == AW'(tcw_pkg::CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      // take an item, saturate the cursor into the geometry
      S_IDLE: begin
        if (q_in.valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_in.entry;
          col_nxt   = (col_r > cols_e - CW'(1)) ? cols_e - CW'(1) : col_r;
          row_nxt   = (row_r > rows_e - RW'(1)) ? rows_e - RW'(1) : row_r;
          total_nxt = tcw_pkg::TOT_W'(geo_prod);
          scr_nxt   = 1'b0;
          rc_nxt    = '0;
          ra_nxt    = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_CALC;
        end
      end

      S_CALC: begin
        last_nxt = AW'(total_r - tcw_pkg::TOT_W'(1));
        case (item_r.kind)
          tcw_pkg::K_READ: begin
            ram_raddr = AW'(item_r.cell_index);
            rd_ok_nxt = (item_r.cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT));
            state_nxt = S_RDWAIT;
          end
          tcw_pkg::K_NUL: begin
            state_nxt = S_LATCH;
          end
          default: begin
            if (item_r.kind == tcw_pkg::K_PRINT) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(lin_prod);
              ram_wdata = {cfg.text_attribute, item_r.char_code};
            end
            col_nxt = nc_w;
            row_nxt = nr_w;
            if (nr_w < rows_e) begin
              state_nxt = S_LATCH;
            end else if (rows_e <= RW'(2)) begin
              // small screen: clear instead of scrolling
              scr_nxt   = 1'b1;
              col_nxt   = '0;
              row_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_CLR;
            end else begin
              scr_nxt   = 1'b1;
              row_nxt   = nr_w - RW'(1);
              cnt_nxt   = AW'(cols_e);
              state_nxt = S_COPY;
            end
          end
        endcase
      end

      S_RDWAIT: begin
        rc_nxt    = rd_ok_r ? ram_rdata[7:0] : '0;
        ra_nxt    = rd_ok_r ? ram_rdata[15:8] : '0;
        state_nxt = S_RESP;
      end

      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = tcw_pkg::CLEAR_CELL;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == last_r) begin
          state_nxt = S_LATCH;
        end
      end

      // move each cell up one row: read cell i+cols, write cell i in the next cycle
      S_COPY: begin
        ram_raddr     = cnt_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r - AW'(cols_e);
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r;
          ram_wdata = ram_rdata;
        end
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == last_r) begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
        pend_nxt  = 1'b0;
        cnt_nxt   = AW'(total_r - tcw_pkg::TOT_W'(cols_e));
        state_nxt = S_FILL;
      end

      // blank the new bottom row
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == last_r) begin
          state_nxt = S_LATCH;
        end
      end

      S_LATCH: begin
        if (item_r.end_of_string) begin
          latch_nxt = tcw_pkg::IDX_W'(lin_prod);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.cursor_column   = col_r;
          out_nxt.cursor_row      = row_r;
          out_nxt.hardware_cursor = latch_r;
          out_nxt.read_char       = rc_r;
          out_nxt.read_attr       = ra_r;
          out_nxt.scrolled        = scr_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      latch_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      latch_r     <= latch_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    item_r      <= item_nxt;
    scr_r       <= scr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rc_r        <= rc_nxt;
    ra_r        <= ra_nxt;
    pend_addr_r <= pend_addr_nxt;
    total_r     <= total_nxt;
    out_r       <= out_nxt;
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_done = (state_r != S_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: tb/text_console_character_writer_tb.sv
// Self-checking testbench for the text console character writer.
`timescale 1ns / 100ps

module text_console_character_writer_tb;

  // Operation codes and the unmapped register slot
  localparam logic       OP_PUT    = 1'b0;
  localparam logic       OP_READ   = 1'b1;
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Slowest run: clearing pass plus every beat a full-screen scroll with stalls, several times over
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // Screen model and store of expected result beats
  class console_scoreboard;
    tcw_pkg::out_t              pending_results[$];
    logic [tcw_pkg::CELL_W-1:0] screen[tcw_pkg::CELL_COUNT];
    int unsigned                col, row, hw_cursor;
    logic [tcw_pkg::COL_W-1:0]  columns_reg;
    logic [tcw_pkg::ROW_W-1:0]  rows_reg;
    logic [tcw_pkg::CHAR_W-1:0] attr_reg;
    int                         errors;
    int                         results_seen;

    function new();
      for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) screen[i] = '0;
      col = 0;
      row = 0;
      hw_cursor = 0;
      columns_reg = tcw_pkg::COLS_RST;
      rows_reg = tcw_pkg::ROWS_RST;
      attr_reg = tcw_pkg::ATTR_RST;
      errors = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        tcw_pkg::REG_COLUMNS: columns_reg = value[tcw_pkg::COL_W-1:0];
        tcw_pkg::REG_ROWS:    rows_reg = value[tcw_pkg::ROW_W-1:0];
        tcw_pkg::REG_ATTR:    attr_reg = value[tcw_pkg::CHAR_W-1:0];
        default:              ;
      endcase
    endfunction

    // Geometry in use: zero acts as one, oversize acts as the maximum
    function int unsigned active_cols();
      if (columns_reg == '0) return 1;
      if (columns_reg > tcw_pkg::MAX_COLS) return tcw_pkg::MAX_COLS;
      return 32'(columns_reg);
    endfunction

    function int unsigned active_rows();
      if (rows_reg == '0) return 1;
      if (rows_reg > tcw_pkg::MAX_ROWS) return tcw_pkg::MAX_ROWS;
      return 32'(rows_reg);
    endfunction

    // Apply one put to the cursor and screen; returns 1 on scroll or clear
    function bit apply_char(logic [tcw_pkg::CHAR_W-1:0] ch, int unsigned cols,
                            int unsigned nrows);
      int unsigned c, r, total, i;
      c = col;
      r = row;
      if (ch == tcw_pkg::CH_NUL) return 1'b0;
      case (ch)
        tcw_pkg::CH_TAB: c = c + 4 - (c % 4);
        tcw_pkg::CH_NL: begin
          c = 0;
          r++;
        end
        tcw_pkg::CH_CR: c = 0;
        default: begin
          screen[r * cols + c] = {attr_reg, ch};
          c++;
        end
      endcase
      if (c >= cols) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
      if (r < nrows) return 1'b0;
      total = cols * nrows;
      if (nrows <= 2) begin
        // tiny screens are wiped instead of scrolled
        for (i = 0; i < total; i++) screen[i] = tcw_pkg::CLEAR_CELL;
        col = 0;
        row = 0;
      end else begin
        for (i = 0; i + cols < total; i++) screen[i] = screen[i + cols];
        for (i = total - cols; i < total; i++) screen[i] = '0;
        row = r - 1;
      end
      return 1'b1;
    endfunction

    function void note_input(tcw_pkg::in_t beat);
      int unsigned cols, nrows;
      tcw_pkg::out_t want;
      cols = active_cols();
      nrows = active_rows();
      // cursor is pulled back inside the geometry first
      if (col > cols - 1) col = cols - 1;
      if (row > nrows - 1) row = nrows - 1;
      want = '0;
      if (beat.operation == OP_READ) begin
        if (beat.cell_index < tcw_pkg::CELL_COUNT) begin
          want.read_char = screen[beat.cell_index][7:0];
          want.read_attr = screen[beat.cell_index][15:8];
        end
      end else begin
        want.scrolled = apply_char(beat.char_code, cols, nrows);
        if (beat.end_of_string) hw_cursor = (row * cols + col) & 32'h7FF;
      end
      want.cursor_column = tcw_pkg::COL_W'(col);
      want.cursor_row = tcw_pkg::ROW_W'(row);
      want.hardware_cursor = tcw_pkg::IDX_W'(hw_cursor);
      pending_results.push_back(want);
    endfunction

    // Every mismatch prints one line and is counted
    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s = %0h, expected %0h",
                                  results_seen, name, got, want));
    endtask

    task check_result(tcw_pkg::out_t got);
      tcw_pkg::out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        results_seen++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("cursor_column", 16'(got.cursor_column), 16'(want.cursor_column));
      compare_field("cursor_row", 16'(got.cursor_row), 16'(want.cursor_row));
      compare_field("hardware_cursor", 16'(got.hardware_cursor),
                    16'(want.hardware_cursor));
      compare_field("read_char", 16'(got.read_char), 16'(want.read_char));
      compare_field("read_attr", 16'(got.read_attr), 16'(want.read_attr));
      compare_field("scrolled", 16'(got.scrolled), 16'(want.scrolled));
      results_seen++;
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  tcw_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  tcw_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  int          tx_idle_pct = 22;
  int          rx_idle_pct = 48;
  int unsigned cycle_count = 0;
  console_scoreboard sb;

  text_console_character_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL text_console_character_writer");
      $finish;
    end
  end

  function automatic tcw_pkg::in_t make_beat(logic op, logic [tcw_pkg::CHAR_W-1:0] ch,
                                             logic eos, logic [tcw_pkg::IDX_W-1:0] idx);
    tcw_pkg::in_t b;
    b.operation = op;
    b.char_code = ch;
    b.end_of_string = eos;
    b.cell_index = idx;
    return b;
  endfunction

  // Control codes weighted up, the rest any byte
  function automatic logic [tcw_pkg::CHAR_W-1:0] pick_char(int nl_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < nl_pct) return tcw_pkg::CH_NL;
    if (r < nl_pct + 6) return tcw_pkg::CH_NUL;
    if (r < nl_pct + 16) return tcw_pkg::CH_TAB;
    if (r < nl_pct + 22) return tcw_pkg::CH_CR;
    return tcw_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  // Valid stays up between back-to-back beats
  task automatic send_beat(input tcw_pkg::in_t beat);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and let every expected result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Setup then access; caller returns the bus to idle after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic random_items(input int n_items, input int nl_pct);
    int sent, len, cells;
    logic [tcw_pkg::IDX_W-1:0] idx;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        // cell read, mostly inside the visible area
        cells = sb.active_cols() * sb.active_rows();
        if ($urandom_range(0, 99) < 70) idx = tcw_pkg::IDX_W'($urandom_range(0, cells - 1));
        else idx = tcw_pkg::IDX_W'($urandom_range(0, 2047));
        send_beat(make_beat(OP_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), idx));
        sent++;
      end else begin
        // one string, terminated on its last character
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_beat(make_beat(OP_PUT, pick_char(nl_pct),
                              (k == len - 1) || ($urandom_range(0, 99) < 5),
                              tcw_pkg::IDX_W'($urandom_range(0, 2047))));
        end
        sent += len;
      end
    end
  endtask

  task automatic run_phase(input logic [tcw_pkg::COL_W-1:0] cols_val,
                           input logic [tcw_pkg::ROW_W-1:0] rows_val,
                           input logic [tcw_pkg::CHAR_W-1:0] attr_val, input bit spare_write,
                           input int tx_pct, input int rx_pct, input int n_items,
                           input int nl_pct);
    wait_idle();
    // upper data bits are don't-care, so fill them with noise
    write_reg(tcw_pkg::REG_COLUMNS, ($urandom() & ~32'h7F) | 32'(cols_val));
    write_reg(tcw_pkg::REG_ROWS, ($urandom() & ~32'h1F) | 32'(rows_val));
    write_reg(tcw_pkg::REG_ATTR, ($urandom() & ~32'hFF) | 32'(attr_val));
    if (spare_write) write_reg(REG_SPARE, $urandom());
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    @(posedge clk);
    random_items(n_items, nl_pct);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats on the reset geometry
    send_beat(make_beat(OP_READ, 8'hFF, 1'b1, 11'd0));
    send_beat(make_beat(OP_PUT, 8'h41, 1'b0, 11'h7FF));
    send_beat(make_beat(OP_PUT, 8'hFF, 1'b0, 11'h000));
    send_beat(make_beat(OP_PUT, 8'h01, 1'b1, 11'h555));
    send_beat(make_beat(OP_PUT, tcw_pkg::CH_NUL, 1'b1, 11'h2AA));
    send_beat(make_beat(OP_PUT, tcw_pkg::CH_TAB, 1'b0, 11'd3));
    send_beat(make_beat(OP_PUT, tcw_pkg::CH_TAB, 1'b1, 11'd9));
    send_beat(make_beat(OP_PUT, tcw_pkg::CH_CR, 1'b0, 11'd17));
    send_beat(make_beat(OP_PUT, tcw_pkg::CH_NL, 1'b1, 11'd40));
    send_beat(make_beat(OP_PUT, 8'h7F, 1'b0, 11'd0));
    send_beat(make_beat(OP_PUT, 8'h80, 1'b1, 11'd1));
    send_beat(make_beat(OP_PUT, 8'h0B, 1'b0, 11'd2));
    send_beat(make_beat(OP_PUT, 8'hFE, 1'b0, 11'd1024));
    send_beat(make_beat(OP_PUT, tcw_pkg::CH_NUL, 1'b0, 11'd7));
    send_beat(make_beat(OP_READ, 8'h00, 1'b0, 11'd0));
    send_beat(make_beat(OP_READ, 8'h00, 1'b0, 11'd1));
    send_beat(make_beat(OP_READ, 8'h0A, 1'b1, 11'd80));
    send_beat(make_beat(OP_READ, 8'h00, 1'b0, 11'd1999));
    send_beat(make_beat(OP_READ, 8'h00, 1'b0, 11'd2000));
    send_beat(make_beat(OP_READ, 8'h0D, 1'b1, 11'h7FF));

    // Oversized geometry acts as full screen, newline-heavy to force scrolls
    run_phase(7'd127, 5'd31, 8'h00, 1'b0, 22, 48, 90, 40);
    // Shrinks the screen under the cursor
    run_phase(7'd13, 5'd5, 8'($urandom_range(0, 255)), 1'b1, 22, 48, 60, 15);
    run_phase(7'd0, 5'd0, 8'hFF, 1'b0, 48, 22, 55, 15);
    run_phase(7'd7, 5'd2, 8'($urandom_range(0, 255)), 1'b0, 48, 22, 60, 15);
    run_phase(7'd4, 5'd3, 8'($urandom_range(0, 255)), 1'b1, 0, 0, 60, 15);
    run_phase(7'd1, 5'd25, 8'($urandom_range(0, 255)), 1'b0, 0, 0, 60, 10);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS text_console_character_writer");
    end else begin
      $display("FAIL text_console_character_writer");
    end
    $finish;
  end

endmodule
